// ===== rtl/core/stt_pkg.sv =====
// Shared types, codes and constants for the sorted timer table.
package stt_pkg;

   // Default number of timer cells in the chain
   localparam int TABLE_DEPTH_DEF = 16;

   // Field widths
   localparam int ACTION_W   = 3;
   localparam int DELAY_W    = 32;
   localparam int TAG_W      = 8;
   localparam int OWNER_W    = 8;
   localparam int PARAM_W    = 32;
   localparam int TIME_W     = 48;
   localparam int STATUS_W   = 2;
   localparam int REMOVED_W  = 5;
   localparam int REMOVED_MAX = 31;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_CHECK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_CANCEL = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd2;

   // Cell operation codes
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_POP    = 2'd2;
   localparam logic [1:0] CELL_PURGE  = 2'd3;

   // One stored timer
   typedef struct packed {
      logic [TIME_W-1:0]  deadline;
      logic [OWNER_W-1:0] owner;
      logic [TAG_W-1:0]   tag;
      logic [PARAM_W-1:0] ctx;
   } entry_type;

   // Broadcast control from the sequencer to every cell
   typedef struct packed {
      logic [1:0] op;
      logic       owner_only;
      entry_type  key;
   } cell_ctrl_type;

   // Flags handed from one cell to the next
   typedef struct packed {
      logic stay;
      logic shift;
      logic purge;
   } link_type;

endpackage

// ===== rtl/core/sorted_timer_table_core.sv =====
// Top level of the sorted timer table: sequencer, time counter and cell chain.
// Order: a beat is captured into the request registers and executed; its result is registered
//   once the output is free, and cancel and delete first remove every matching entry.
// Throughput: one request in flight; the cell chain drops one matching entry per cycle
//   during cancel/delete. A new request is taken while a result waits.
// Reset: synchronous active-high reset empties the table, zeroes the time counter and
//   drops any pending result beat; entry and result payloads are not cleared.
module sorted_timer_table_core #(
   parameter int TABLE_DEPTH = stt_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [stt_pkg::ACTION_W-1:0]   req_action,
   input  logic [stt_pkg::DELAY_W-1:0]    req_delay_ms,
   input  logic [stt_pkg::TAG_W-1:0]      req_tag,
   input  logic [stt_pkg::OWNER_W-1:0]    req_owner,
   input  logic [stt_pkg::PARAM_W-1:0]    req_param,
   input  logic [stt_pkg::TIME_W-1:0]     req_deadline,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [stt_pkg::STATUS_W-1:0]   rsp_status,
   output logic                           rsp_fired,
   output logic [stt_pkg::TIME_W-1:0]     rsp_due_time,
   output logic [stt_pkg::OWNER_W-1:0]    rsp_fired_owner,
   output logic [stt_pkg::TAG_W-1:0]      rsp_fired_tag,
   output logic [stt_pkg::PARAM_W-1:0]    rsp_fired_param,
   output logic [stt_pkg::REMOVED_W-1:0]  rsp_removed
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int SAT_W = (CNT_W > stt_pkg::REMOVED_W) ? CNT_W : stt_pkg::REMOVED_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   // Sequencer and request registers
   logic                          state_ff, state_in;
   logic [stt_pkg::ACTION_W-1:0]  act_ff, act_in;
   stt_pkg::entry_type            key_ff, key_in;
   logic [stt_pkg::TIME_W-1:0]    now_ff, now_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;

   // Result register
   logic                          rv_ff, rv_in;
   logic [stt_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic                          fired_ff, fired_in;
   logic [stt_pkg::TIME_W-1:0]    due_ff, due_in;
   logic [stt_pkg::OWNER_W-1:0]   fowner_ff, fowner_in;
   logic [stt_pkg::TAG_W-1:0]     ftag_ff, ftag_in;
   logic [stt_pkg::PARAM_W-1:0]   fparam_ff, fparam_in;
   logic [stt_pkg::REMOVED_W-1:0] removed_ff, removed_in;

   // Chain wiring
   stt_pkg::cell_ctrl_type ctrl_w;
   stt_pkg::link_type      link_w [TABLE_DEPTH+1];
   logic                   vld_w  [TABLE_DEPTH];
   stt_pkg::entry_type     ent_w  [TABLE_DEPTH];

   logic             accept_w;
   logic             out_free_w;
   logic             purge_act_w;
   logic             full_w;
   logic             due_w;
   logic             done_w;
   logic [SAT_W-1:0] cnt_ext_w;

   assign link_w[0] = '{stay: 1'b1, shift: 1'b0, purge: 1'b0};

   // Cell chain
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      stt_pkg::entry_type prev_e;
      stt_pkg::entry_type next_e;
      logic               next_v;
      if (i == 0) begin : g_first
         assign prev_e = '0;
      end else begin : g_mid
         assign prev_e = ent_w[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_last
         assign next_e = '0;
         assign next_v = 1'b0;
      end else begin : g_inner
         assign next_e = ent_w[i+1];
         assign next_v = vld_w[i+1];
      end
      stt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl_w),
         .link_i     (link_w[i]),
         .link_o     (link_w[i+1]),
         .prev_entry (prev_e),
         .next_valid (next_v),
         .next_entry (next_e),
         .valid      (vld_w[i]),
         .entry      (ent_w[i])
      );
   end

   // Status of the chain
   always_comb begin
      accept_w    = req_valid && !req_stall;
      out_free_w  = !rv_ff || !rsp_stall;
      purge_act_w = (act_ff == stt_pkg::ACT_CANCEL) || (act_ff == stt_pkg::ACT_DELETE);
      full_w      = vld_w[TABLE_DEPTH-1];
      due_w       = vld_w[0] && (ent_w[0].deadline < now_ff);
      done_w      = (state_ff == ST_EXEC) && out_free_w &&
                    !(purge_act_w && link_w[TABLE_DEPTH].purge);
      cnt_ext_w   = SAT_W'(cnt_ff);
   end

   // Cell control
   always_comb begin
      ctrl_w.op         = stt_pkg::CELL_HOLD;
      ctrl_w.owner_only = (act_ff == stt_pkg::ACT_DELETE);
      ctrl_w.key        = key_ff;
      if (state_ff == ST_EXEC) begin
         if (purge_act_w) begin
            ctrl_w.op = stt_pkg::CELL_PURGE;
         end else if ((act_ff == stt_pkg::ACT_ADD) && out_free_w && !full_w) begin
            ctrl_w.op = stt_pkg::CELL_INSERT;
         end else if ((act_ff == stt_pkg::ACT_CHECK) && out_free_w && due_w) begin
            ctrl_w.op = stt_pkg::CELL_POP;
         end
      end
   end

   // Sequencer, counter and request capture
   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      key_in   = key_ff;
      now_in   = now_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_w) begin
               state_in      = ST_EXEC;
               act_in        = req_action;
               key_in.owner  = req_owner;
               key_in.tag    = req_tag;
               key_in.ctx    = req_param;
               key_in.deadline = (req_action == stt_pkg::ACT_ADD) ?
                                 now_ff + stt_pkg::TIME_W'(req_delay_ms) : req_deadline;
               cnt_in        = '0;
            end
         end
         ST_EXEC: begin
            if (purge_act_w && link_w[TABLE_DEPTH].purge) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (done_w) begin
               state_in = ST_IDLE;
               if (act_ff == stt_pkg::ACT_TICK) begin
                  now_in = now_ff + stt_pkg::TIME_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result beat
   always_comb begin
      rv_in      = rv_ff && rsp_stall;
      status_in  = status_ff;
      fired_in   = fired_ff;
      due_in     = due_ff;
      fowner_in  = fowner_ff;
      ftag_in    = ftag_ff;
      fparam_in  = fparam_ff;
      removed_in = removed_ff;
      if (done_w) begin
         rv_in      = 1'b1;
         status_in  = stt_pkg::STATUS_DONE;
         fired_in   = 1'b0;
         due_in     = '0;
         fowner_in  = '0;
         ftag_in    = '0;
         fparam_in  = '0;
         removed_in = '0;
         unique case (act_ff)
            stt_pkg::ACT_ADD: begin
               if (full_w) begin
                  status_in = stt_pkg::STATUS_FULL;
               end else begin
                  due_in = key_ff.deadline;
               end
            end
            stt_pkg::ACT_CHECK: begin
               if (due_w) begin
                  fired_in  = 1'b1;
                  due_in    = ent_w[0].deadline;
                  fowner_in = ent_w[0].owner;
                  ftag_in   = ent_w[0].tag;
                  fparam_in = ent_w[0].ctx;
               end else begin
                  status_in = stt_pkg::STATUS_NONE;
               end
            end
            stt_pkg::ACT_CANCEL, stt_pkg::ACT_DELETE: begin
               if (cnt_ff == '0) begin
                  status_in = stt_pkg::STATUS_NONE;
               end
               removed_in = (cnt_ext_w > SAT_W'(stt_pkg::REMOVED_MAX)) ?
                            stt_pkg::REMOVED_W'(stt_pkg::REMOVED_MAX) :
                            cnt_ext_w[stt_pkg::REMOVED_W-1:0];
            end
            default: begin
               status_in = stt_pkg::STATUS_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         now_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         now_ff   <= now_in;
         rv_ff    <= rv_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      key_ff     <= key_in;
      cnt_ff     <= cnt_in;
      status_ff  <= status_in;
      fired_ff   <= fired_in;
      due_ff     <= due_in;
      fowner_ff  <= fowner_in;
      ftag_ff    <= ftag_in;
      fparam_ff  <= fparam_in;
      removed_ff <= removed_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rv_ff;
   assign rsp_status      = status_ff;
   assign rsp_fired       = fired_ff;
   assign rsp_due_time    = due_ff;
   assign rsp_fired_owner = fowner_ff;
   assign rsp_fired_tag   = ftag_ff;
   assign rsp_fired_param = fparam_ff;
   assign rsp_removed     = removed_ff;

endmodule

// ===== rtl/core/stt_cell.sv =====
// One cell of the sorted timer chain: holds a single timer slot.
module stt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  stt_pkg::cell_ctrl_type ctrl,
   input  stt_pkg::link_type     link_i,
   output stt_pkg::link_type     link_o,
   input  stt_pkg::entry_type    prev_entry,
   input  logic                  next_valid,
   input  stt_pkg::entry_type    next_entry,
   output logic                  valid,
   output stt_pkg::entry_type    entry
);

   logic               valid_ff, valid_in;
   stt_pkg::entry_type entry_ff, entry_in;
   logic               later_w;
   logic               hit_w;

   // Compare against the broadcast key
   always_comb begin
      later_w = entry_ff.deadline > ctrl.key.deadline;
      hit_w   = valid_ff && (entry_ff.owner == ctrl.key.owner) &&
                (ctrl.owner_only ||
                 ((entry_ff.tag == ctrl.key.tag) &&
                  (entry_ff.deadline == ctrl.key.deadline)));
      link_o.stay  = valid_ff && !later_w;
      link_o.shift = valid_ff && later_w;
      link_o.purge = link_i.purge | hit_w;
   end

   // Next slot contents
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      unique case (ctrl.op)
         stt_pkg::CELL_HOLD: begin
            valid_in = valid_ff;
         end
         stt_pkg::CELL_INSERT: begin
            if (link_i.shift) begin
               valid_in = 1'b1;
               entry_in = prev_entry;
            end else if (link_i.stay && !link_o.stay) begin
               valid_in = 1'b1;
               entry_in = ctrl.key;
            end
         end
         stt_pkg::CELL_POP: begin
            valid_in = next_valid;
            entry_in = next_entry;
         end
         stt_pkg::CELL_PURGE: begin
            if (link_o.purge) begin
               valid_in = next_valid;
               entry_in = next_entry;
            end
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload carries no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

// ===== rtl/core/stt_checker.sv =====
// Port-level checks for the sorted timer table, bound to the top level.
module stt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [stt_pkg::STATUS_W-1:0]  rsp_status,
   input logic                          rsp_fired,
   input logic [stt_pkg::TIME_W-1:0]    rsp_due_time,
   input logic [stt_pkg::OWNER_W-1:0]   rsp_fired_owner,
   input logic [stt_pkg::TAG_W-1:0]     rsp_fired_tag,
   input logic [stt_pkg::PARAM_W-1:0]   rsp_fired_param,
   input logic [stt_pkg::REMOVED_W-1:0] rsp_removed
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_due_time) && $stable(rsp_removed) && $stable(rsp_fired))
      else $error("stalled result beat changed");

   // A fired timer always reports done and nothing removed
   a_fired_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> rsp_status == stt_pkg::STATUS_DONE && rsp_removed == '0)
      else $error("fired timer with bad status");

   // Full table reports no deadline
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == stt_pkg::STATUS_FULL |->
      rsp_due_time == '0 && !rsp_fired && rsp_removed == '0)
      else $error("full status with payload");

   // Owner, tag and context only show up on a fired timer
   a_fire_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |->
      rsp_fired_owner == '0 && rsp_fired_tag == '0 && rsp_fired_param == '0)
      else $error("fired fields set without fire");

endmodule

bind sorted_timer_table_core stt_checker u_stt_checker (.*);

// ===== sim/sorted_timer_table_core_tb.sv =====
// Self-checking testbench for the sorted timer table core: directed rows, then random traffic.
`timescale 1ns / 1ps

module sorted_timer_table_core_tb;

   localparam int DEPTH       = stt_pkg::TABLE_DEPTH_DEF;
   localparam int N_RANDOM    = 1700;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_AT     = 500;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN       = 40;

   // action codes the block ignores
   localparam logic [stt_pkg::ACTION_W-1:0] ACT_UNUSED_A = 3'd5;
   localparam logic [stt_pkg::ACTION_W-1:0] ACT_UNUSED_B = 3'd6;
   localparam logic [stt_pkg::ACTION_W-1:0] ACT_UNUSED_C = 3'd7;

   typedef struct packed {
      logic [stt_pkg::ACTION_W-1:0] action;
      logic [stt_pkg::DELAY_W-1:0]  delay;
      logic [stt_pkg::TAG_W-1:0]    tag;
      logic [stt_pkg::OWNER_W-1:0]  owner;
      logic [stt_pkg::PARAM_W-1:0]  param;
      logic [stt_pkg::TIME_W-1:0]   deadline;
   } timer_req_type;

   typedef struct packed {
      logic [stt_pkg::STATUS_W-1:0]  status;
      logic                          fired;
      logic [stt_pkg::TIME_W-1:0]    due;
      logic [stt_pkg::OWNER_W-1:0]   owner;
      logic [stt_pkg::TAG_W-1:0]     tag;
      logic [stt_pkg::PARAM_W-1:0]   param;
      logic [stt_pkg::REMOVED_W-1:0] removed;
   } timer_rsp_type;

   typedef struct {
      timer_req_type req;
      int            reps;
      bit            typed;
      timer_rsp_type want;
   } dir_row_type;

   logic clock;
   logic reset = 1'b1;

   logic                          req_valid    = 1'b0;
   logic                          req_stall;
   logic [stt_pkg::ACTION_W-1:0]  req_action   = '0;
   logic [stt_pkg::DELAY_W-1:0]   req_delay_ms = '0;
   logic [stt_pkg::TAG_W-1:0]     req_tag      = '0;
   logic [stt_pkg::OWNER_W-1:0]   req_owner    = '0;
   logic [stt_pkg::PARAM_W-1:0]   req_param    = '0;
   logic [stt_pkg::TIME_W-1:0]    req_deadline = '0;
   logic                          rsp_valid;
   logic                          rsp_stall    = 1'b0;
   logic [stt_pkg::STATUS_W-1:0]  rsp_status;
   logic                          rsp_fired;
   logic [stt_pkg::TIME_W-1:0]    rsp_due_time;
   logic [stt_pkg::OWNER_W-1:0]   rsp_fired_owner;
   logic [stt_pkg::TAG_W-1:0]     rsp_fired_tag;
   logic [stt_pkg::PARAM_W-1:0]   rsp_fired_param;
   logic [stt_pkg::REMOVED_W-1:0] rsp_removed;

   logic hold_off = 1'b0;

   // mirror of the timer table
   logic [stt_pkg::TIME_W-1:0] tmr_now;
   stt_pkg::entry_type         tmr_table [DEPTH];
   int                         tmr_count;

   timer_rsp_type owed_replies [$];
   int sent_count  = 0;
   int rsp_seen    = 0;
   int err_count   = 0;
   int cycle_count = 0;
   int n_fired     = 0;
   int n_full      = 0;
   int n_removed   = 0;

   sorted_timer_table_core #(.TABLE_DEPTH(DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_delay_ms    (req_delay_ms),
      .req_tag         (req_tag),
      .req_owner       (req_owner),
      .req_param       (req_param),
      .req_deadline    (req_deadline),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_fired       (rsp_fired),
      .rsp_due_time    (rsp_due_time),
      .rsp_fired_owner (rsp_fired_owner),
      .rsp_fired_tag   (rsp_fired_tag),
      .rsp_fired_param (rsp_fired_param),
      .rsp_removed     (rsp_removed)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Apply one action to the mirrored table and return the reply it owes
   function automatic timer_rsp_type apply_timer_action(input timer_req_type r);
      timer_rsp_type      o;
      stt_pkg::entry_type e;
      int                 pos;
      int                 kept;
      int                 dropped;
      logic               hit;
      o = '0;
      case (r.action)
         stt_pkg::ACT_ADD: begin
            if (tmr_count >= DEPTH) begin
               o.status = stt_pkg::STATUS_FULL;
            end else begin
               e.deadline = tmr_now + stt_pkg::TIME_W'(r.delay);
               e.owner    = r.owner;
               e.tag      = r.tag;
               e.ctx      = r.param;
               // equal deadlines go behind the ones already stored
               pos = 0;
               while (pos < tmr_count && tmr_table[pos].deadline <= e.deadline) pos++;
               for (int i = tmr_count; i > pos; i--) tmr_table[i] = tmr_table[i-1];
               tmr_table[pos] = e;
               tmr_count++;
               o.due = e.deadline;
            end
         end
         stt_pkg::ACT_CHECK: begin
            if (tmr_count == 0 || !(tmr_table[0].deadline < tmr_now)) begin
               o.status = stt_pkg::STATUS_NONE;
            end else begin
               o.fired = 1'b1;
               o.due   = tmr_table[0].deadline;
               o.owner = tmr_table[0].owner;
               o.tag   = tmr_table[0].tag;
               o.param = tmr_table[0].ctx;
               for (int i = 1; i < tmr_count; i++) tmr_table[i-1] = tmr_table[i];
               tmr_count--;
            end
         end
         stt_pkg::ACT_CANCEL, stt_pkg::ACT_DELETE: begin
            kept = 0;
            for (int i = 0; i < tmr_count; i++) begin
               hit = (tmr_table[i].owner == r.owner);
               if (r.action == stt_pkg::ACT_CANCEL)
                  hit = hit && tmr_table[i].tag == r.tag &&
                        tmr_table[i].deadline == r.deadline;
               if (!hit) begin
                  tmr_table[kept] = tmr_table[i];
                  kept++;
               end
            end
            dropped   = tmr_count - kept;
            tmr_count = kept;
            o.status  = (dropped != 0) ? stt_pkg::STATUS_DONE : stt_pkg::STATUS_NONE;
            o.removed = stt_pkg::REMOVED_W'((dropped > stt_pkg::REMOVED_MAX) ?
                                            stt_pkg::REMOVED_MAX : dropped);
         end
         stt_pkg::ACT_TICK: begin
            tmr_now = tmr_now + 1'b1;
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   function automatic timer_rsp_type make_reply(
         input logic [stt_pkg::STATUS_W-1:0] status,
         input logic fired, input logic [stt_pkg::TIME_W-1:0] due,
         input logic [stt_pkg::OWNER_W-1:0] owner,
         input logic [stt_pkg::TAG_W-1:0] tag,
         input logic [stt_pkg::PARAM_W-1:0] param,
         input logic [stt_pkg::REMOVED_W-1:0] removed);
      timer_rsp_type o;
      o.status  = status;
      o.fired   = fired;
      o.due     = due;
      o.owner   = owner;
      o.tag     = tag;
      o.param   = param;
      o.removed = removed;
      return o;
   endfunction

   function automatic dir_row_type make_row(
         input logic [stt_pkg::ACTION_W-1:0] action,
         input logic [stt_pkg::DELAY_W-1:0] delay,
         input logic [stt_pkg::TAG_W-1:0] tag,
         input logic [stt_pkg::OWNER_W-1:0] owner,
         input logic [stt_pkg::PARAM_W-1:0] param,
         input logic [stt_pkg::TIME_W-1:0] deadline,
         input int reps, input bit typed,
         input timer_rsp_type want);
      dir_row_type d;
      d.req.action   = action;
      d.req.delay    = delay;
      d.req.tag      = tag;
      d.req.owner    = owner;
      d.req.param    = param;
      d.req.deadline = deadline;
      d.reps         = reps;
      d.typed        = typed;
      d.want         = want;
      return d;
   endfunction

   // Random request, shaped by what the table holds right now
   function automatic timer_req_type pick_request(input bit fill_phase);
      timer_req_type r;
      int            roll;
      int            k;
      r.delay    = $urandom;
      r.param    = $urandom;
      r.deadline = {16'($urandom), 32'($urandom)};
      // small owner and tag pools so deletes and cancels hit
      r.owner    = ($urandom_range(0, 3) == 0) ? stt_pkg::OWNER_W'($urandom) :
                                                  stt_pkg::OWNER_W'($urandom_range(0, 3));
      r.tag      = ($urandom_range(0, 3) == 0) ? stt_pkg::TAG_W'($urandom) :
                                                  stt_pkg::TAG_W'($urandom_range(0, 3));
      roll = $urandom_range(0, 99);
      if (roll < (fill_phase ? 45 : 15))      r.action = stt_pkg::ACT_ADD;
      else if (roll < (fill_phase ? 65 : 45)) r.action = stt_pkg::ACT_TICK;
      else if (roll < (fill_phase ? 80 : 75)) r.action = stt_pkg::ACT_CHECK;
      else if (roll < (fill_phase ? 90 : 88)) r.action = stt_pkg::ACT_CANCEL;
      else if (roll < 97)                     r.action = stt_pkg::ACT_DELETE;
      else r.action = stt_pkg::ACTION_W'($urandom_range(ACT_UNUSED_A, ACT_UNUSED_C));

      if (r.action == stt_pkg::ACT_ADD) begin
         roll = $urandom_range(0, 99);
         if (roll < 4)       r.delay = '0;
         else if (roll < 90) r.delay = stt_pkg::DELAY_W'($urandom_range(0, 30));
      end else if (r.action == stt_pkg::ACT_CANCEL) begin
         roll = $urandom_range(0, 99);
         if (tmr_count > 0 && roll < 70) begin
            // aim at a stored entry, now and then with the wrong tag
            k = $urandom_range(0, tmr_count - 1);
            r.deadline = tmr_table[k].deadline;
            r.owner    = tmr_table[k].owner;
            r.tag      = tmr_table[k].tag ^ stt_pkg::TAG_W'(roll < 8);
         end else if (roll < 85) begin
            r.deadline = tmr_now + stt_pkg::TIME_W'($urandom_range(0, 30));
         end
      end
      return r;
   endfunction

   // Idle cycles before the next request: mostly none or short, a few long
   function automatic int gap_cycles();
      int roll;
      if ((sent_count / 128) % 5 == 4) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      err_count++;
      $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", rsp_seen, what, got, want);
   endtask

   // Offer one beat, hold it until taken, then record what it owes
   task automatic send_request(input timer_req_type r, input bit typed,
                               input timer_rsp_type want);
      int            gap;
      timer_rsp_type owed;
      gap = gap_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= r.action;
      req_delay_ms <= r.delay;
      req_tag      <= r.tag;
      req_owner    <= r.owner;
      req_param    <= r.param;
      req_deadline <= r.deadline;
      do @(posedge clock); while (req_stall);
      owed = apply_timer_action(r);
      owed_replies.push_back(typed ? want : owed);
      sent_count++;
   endtask

   task automatic check_result();
      timer_rsp_type want;
      rsp_seen++;
      if (owed_replies.size() == 0) begin
         report_mismatch("result with nothing owed, status", rsp_status, '0);
      end else begin
         want = owed_replies.pop_front();
         if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
         if (rsp_fired !== want.fired) report_mismatch("fired", rsp_fired, want.fired);
         if (rsp_due_time !== want.due) report_mismatch("due_time", rsp_due_time, want.due);
         if (rsp_fired_owner !== want.owner)
            report_mismatch("fired_owner", rsp_fired_owner, want.owner);
         if (rsp_fired_tag !== want.tag) report_mismatch("fired_tag", rsp_fired_tag, want.tag);
         if (rsp_fired_param !== want.param)
            report_mismatch("fired_param", rsp_fired_param, want.param);
         if (rsp_removed !== want.removed)
            report_mismatch("removed", rsp_removed, want.removed);
      end
      if (rsp_fired === 1'b1) n_fired++;
      if (rsp_status === stt_pkg::STATUS_FULL) n_full++;
      n_removed += rsp_removed;
   endtask

   // Result side: random stalls, calm stretches, and the long hold-off
   initial begin : rsp_side
      int stall_left;
      int rx_cycles;
      int roll;
      stall_left = 0;
      rx_cycles  = 0;
      forever begin
         @(posedge clock);
         rx_cycles++;
         if (!reset && rsp_valid && !rsp_stall) check_result();
         if (stall_left > 0) begin
            stall_left--;
         end else if ((rx_cycles / 512) % 4 != 1) begin
            roll = $urandom_range(0, 99);
            if (roll < 60)      stall_left = 0;
            else if (roll < 95) stall_left = $urandom_range(1, 3);
            else                stall_left = $urandom_range(20, 60);
         end
         rsp_stall <= hold_off || (stall_left > 0);
      end
   end

   // Long receiver hold-off so the block fills and stalls its input
   initial begin : hold_off_ctl
      int held;
      held = 0;
      while (sent_count < HOLD_AT) @(negedge clock);
      hold_off = 1'b1;
      while (held < HOLD_CYCLES) begin
         @(negedge clock);
         held++;
      end
      hold_off = 1'b0;
   end

   // Cycle limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               owed_replies.size());
      $display("*** FAILED ***");
      $finish;
   end

   // Request side: reset, directed rows, random traffic, drain
   initial begin : req_side
      dir_row_type   dir_rows [$];
      timer_req_type r;
      timer_rsp_type none_rsp;
      timer_rsp_type done_rsp;
      none_rsp = make_reply(stt_pkg::STATUS_NONE, 1'b0, '0, '0, '0, '0, '0);
      done_rsp = make_reply(stt_pkg::STATUS_DONE, 1'b0, '0, '0, '0, '0, '0);
      tmr_now   = '0;
      tmr_count = 0;

      // empty table, ignored codes, extremes
      dir_rows.push_back(make_row(stt_pkg::ACT_CHECK, '0, '0, '0, '0, '0, 1, 1, none_rsp));
      dir_rows.push_back(make_row(stt_pkg::ACT_CANCEL, '0, '1, '1, '0, '1, 1, 1, none_rsp));
      dir_rows.push_back(make_row(stt_pkg::ACT_DELETE, '0, '0, '1, '0, '0, 1, 1, none_rsp));
      dir_rows.push_back(make_row(ACT_UNUSED_A, '1, '1, '1, '1, '1, 1, 1, done_rsp));
      dir_rows.push_back(make_row(ACT_UNUSED_B, '1, '1, '1, '1, '1, 1, 1, done_rsp));
      dir_rows.push_back(make_row(ACT_UNUSED_C, '1, '1, '1, '1, '1, 1, 1, done_rsp));
      dir_rows.push_back(make_row(stt_pkg::ACT_ADD, '0, '0, '0, '0, '0, 1, 1, done_rsp));
      dir_rows.push_back(make_row(stt_pkg::ACT_ADD, '1, '1, '1, '1, '0, 1, 1,
         make_reply(stt_pkg::STATUS_DONE, 1'b0, 48'h0000_FFFF_FFFF, '0, '0, '0, '0)));
      // due at now is not yet expired
      dir_rows.push_back(make_row(stt_pkg::ACT_CHECK, '0, '0, '0, '0, '0, 1, 1, none_rsp));
      dir_rows.push_back(make_row(stt_pkg::ACT_TICK, '0, '0, '0, '0, '0, 1, 1, done_rsp));
      dir_rows.push_back(make_row(stt_pkg::ACT_CHECK, '0, '0, '0, '0, '0, 1, 1,
         make_reply(stt_pkg::STATUS_DONE, 1'b1, '0, '0, '0, '0, '0)));
      // three equal deadlines, then cancel only the one with tag 2
      dir_rows.push_back(make_row(stt_pkg::ACT_ADD, 32'd5, 8'd1, 8'd3, 32'hA5A5_A5A5, '0,
         1, 1, make_reply(stt_pkg::STATUS_DONE, 1'b0, 48'd6, '0, '0, '0, '0)));
      dir_rows.push_back(make_row(stt_pkg::ACT_ADD, 32'd5, 8'd1, 8'd3, 32'h5A5A_5A5A, '0,
         1, 1, make_reply(stt_pkg::STATUS_DONE, 1'b0, 48'd6, '0, '0, '0, '0)));
      dir_rows.push_back(make_row(stt_pkg::ACT_ADD, 32'd5, 8'd2, 8'd3, 32'h0000_0001, '0,
         1, 1, make_reply(stt_pkg::STATUS_DONE, 1'b0, 48'd6, '0, '0, '0, '0)));
      dir_rows.push_back(make_row(stt_pkg::ACT_CANCEL, '0, 8'd2, 8'd3, '0, 48'd6, 1, 1,
         make_reply(stt_pkg::STATUS_DONE, 1'b0, '0, '0, '0, '0, 5'd1)));
      dir_rows.push_back(make_row(stt_pkg::ACT_TICK, '0, '0, '0, '0, '0, 6, 0, '0));
      // equal deadlines fire in insertion order
      dir_rows.push_back(make_row(stt_pkg::ACT_CHECK, '0, '0, '0, '0, '0, 1, 1,
         make_reply(stt_pkg::STATUS_DONE, 1'b1, 48'd6, 8'd3, 8'd1, 32'hA5A5_A5A5, '0)));
      dir_rows.push_back(make_row(stt_pkg::ACT_CHECK, '0, '0, '0, '0, '0, 1, 1,
         make_reply(stt_pkg::STATUS_DONE, 1'b1, 48'd6, 8'd3, 8'd1, 32'h5A5A_5A5A, '0)));
      dir_rows.push_back(make_row(stt_pkg::ACT_CHECK, '0, '0, '0, '0, '0, 1, 1, none_rsp));
      // fill the table, each add landing ahead of the last
      dir_rows.push_back(make_row(stt_pkg::ACT_ADD, 32'd100, 8'd9, 8'd7, 32'h1000_0000, '0,
         15, 0, '0));
      dir_rows.push_back(make_row(stt_pkg::ACT_ADD, 32'd1, 8'd4, 8'd4, 32'hFFFF_0000, '0,
         1, 1, make_reply(stt_pkg::STATUS_FULL, 1'b0, '0, '0, '0, '0, '0)));
      dir_rows.push_back(make_row(stt_pkg::ACT_CHECK, '0, '0, '0, '0, '0, 1, 1, none_rsp));
      dir_rows.push_back(make_row(stt_pkg::ACT_DELETE, '0, '0, 8'd7, '0, '0, 1, 1,
         make_reply(stt_pkg::STATUS_DONE, 1'b0, '0, '0, '0, '0, 5'd15)));
      dir_rows.push_back(make_row(stt_pkg::ACT_CANCEL, '0, '1, '1, '0, 48'h0000_FFFF_FFFF,
         1, 1, make_reply(stt_pkg::STATUS_DONE, 1'b0, '0, '0, '0, '0, 5'd1)));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         for (int rep = 0; rep < dir_rows[i].reps; rep++) begin
            r       = dir_rows[i].req;
            r.delay = r.delay - stt_pkg::DELAY_W'(rep);
            r.param = r.param + stt_pkg::PARAM_W'(rep);
            send_request(r, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      // random traffic, alternating fill-heavy and drain-heavy stretches
      for (int n = 0; n < N_RANDOM; n++)
         send_request(pick_request(((n / 200) % 2) == 0), 1'b0, '0);
      req_valid <= 1'b0;

      while (owed_replies.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("run: %0d requests, %0d results checked in %0d cycles, %0d mismatches",
               sent_count, rsp_seen, cycle_count, err_count);
      $display("coverage: %0d timers fired, %0d adds refused on a full table, %0d removed",
               n_fired, n_full, n_removed);
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/stt_pkg.sv
rtl/core/stt_cell.sv
rtl/core/sorted_timer_table_core.sv
rtl/core/stt_checker.sv
sim/sorted_timer_table_core_tb.sv
